[design/sit_pkg.sv]
package sit_pkg;

  localparam int AGE_W   = 8;
  localparam int FIRST_W = 56;
  localparam int HEAD_W  = 64;
  localparam int TAIL_W  = 16;
  localparam int CFG_W   = 5;

  localparam logic [CFG_W-1:0] CAP_RESET = 5'd10;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DUMP   = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMIT     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [AGE_W-1:0]   age;
    logic [FIRST_W-1:0] first;
    logic [HEAD_W-1:0]  head;
    logic [TAIL_W-1:0]  tail;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic insert;   // place new record
    logic reject;   // report full
    logic empty;    // report empty dump
    logic emit;     // emit cell 0 and rotate
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic dump_last;
  } stat_t;

endpackage

[design/sit_ctrl.sv]
module sit_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          op_i,
  input  sit_pkg::stat_t stat_i,
  output sit_pkg::cmd_t  cmd_o,
  output logic          busy_o
);
  import sit_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (op_i == OP_INSERT) begin
            cmd_o.insert = !stat_i.full;
            cmd_o.reject = stat_i.full;
          end else if (stat_i.empty) begin
            cmd_o.empty = 1'b1;
          end else begin
            state_d = S_DUMP;
          end
        end
      end
      S_DUMP: begin
        cmd_o.emit = 1'b1;
        if (stat_i.dump_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q == S_DUMP);

endmodule

[design/sit_datapath.sv]
module sit_datapath #(
  parameter int TABLE_DEPTH = 16,
  parameter int CntW        = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sit_pkg::cmd_t                cmd_i,
  output sit_pkg::stat_t               stat_o,
  input  logic                         cfg_we_i,
  input  logic [sit_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic [sit_pkg::AGE_W-1:0]    key_age_i,
  input  logic [sit_pkg::FIRST_W-1:0]  first_name_i,
  input  logic [sit_pkg::HEAD_W-1:0]   last_name_head_i,
  input  logic [sit_pkg::TAIL_W-1:0]   last_name_tail_i,
  output logic                         valid_o,
  output logic [1:0]                   status_o,
  output sit_pkg::entry_t              out_entry_o,
  output logic [CntW-1:0]              fill_count_o,
  output logic                         last_o
);
  import sit_pkg::*;

  localparam int IdxW = $clog2(TABLE_DEPTH);
  localparam int CmpW = (CntW > CFG_W) ? CntW : CFG_W;

  entry_t           cell_q [TABLE_DEPTH];
  entry_t           cell_d [TABLE_DEPTH];
  entry_t           new_entry;
  logic [TABLE_DEPTH-1:0] gtv;
  logic [CntW-1:0]  count_q, count_d;
  logic [IdxW-1:0]  idx_q;
  logic [CFG_W-1:0] cap_q;
  logic [CmpW-1:0]  lim_ext, dep_ext, eff_lim;

  assign new_entry = '{age: key_age_i, first: first_name_i,
                       head: last_name_head_i, tail: last_name_tail_i};

  // effective limit: clamp to depth
  assign lim_ext = CmpW'(cap_q);
  assign dep_ext = CmpW'(TABLE_DEPTH);
  assign eff_lim = (lim_ext > dep_ext) ? dep_ext : lim_ext;

  assign stat_o.full      = (CmpW'(count_q) >= eff_lim);
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.dump_last = ((CntW'(idx_q) + CntW'(1)) == count_q);

  assign count_d = cmd_i.insert ? count_q + CntW'(1) : count_q;

  // one cell per entry; all compares in parallel
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    localparam logic [CntW-1:0] CI = CntW'(g);
    entry_t rot_src;
    logic   shift_in;

    assign gtv[g] = (CI < count_q) && (cell_q[g].age > key_age_i);

    if (g == 0) begin : g_first
      assign shift_in = 1'b0;
    end else begin : g_rest
      assign shift_in = gtv[g-1];
    end

    if (g == TABLE_DEPTH - 1) begin : g_top
      assign rot_src = cell_q[0];
    end else begin : g_mid
      assign rot_src = ((CI + CntW'(1)) < count_q) ? cell_q[g+1] : cell_q[0];
    end

    always_comb begin
      cell_d[g] = cell_q[g];
      if (cmd_i.insert && (CI <= count_q)) begin
        if (shift_in) begin
          cell_d[g] = cell_q[(g == 0) ? 0 : g-1];
        end else if (gtv[g] || (CI == count_q)) begin
          cell_d[g] = new_entry;
        end
      end else if (cmd_i.emit && (CI < count_q)) begin
        cell_d[g] = rot_src;
      end
    end

    always_ff @(posedge clk_i) begin
      cell_q[g] <= cell_d[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      cap_q   <= CAP_RESET;
      valid_o <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_o <= cmd_i.insert | cmd_i.reject | cmd_i.empty | cmd_i.emit;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      if (cmd_i.emit) begin
        idx_q <= stat_o.dump_last ? '0 : idx_q + IdxW'(1);
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    fill_count_o <= count_d;
    if (cmd_i.emit) begin
      status_o    <= ST_EMIT;
      out_entry_o <= cell_q[0];
      last_o      <= stat_o.dump_last;
    end else begin
      status_o    <= cmd_i.reject ? ST_FULL : (cmd_i.empty ? ST_EMPTY : ST_INSERTED);
      out_entry_o <= '0;
      last_o      <= 1'b1;
    end
  end

endmodule

[design/sorted_insertion_table.sv]
// Channel  Direction  Handshake                 Payload
// -------  ---------  ------------------------  -----------------------------------------
// command  in         start_i & !busy_o         op_i, key_age_i, first_name_i,
//                                               last_name_head_i, last_name_tail_i
// result   out        valid_o (one cycle)       status_o, out_age_o, out_first_name_o,
//                                               out_last_head_o, out_last_tail_o,
//                                               fill_count_o, last_o
// config   in         cfg_we_i                  cfg_data_i (capacity limit)
//
// An insert (or a full reject) gives its result the cycle after accept, and a
// new item may be accepted in that same cycle.
// A dump of N entries holds busy_o while it emits them, one entry per cycle;
// an empty dump gives a single result.
// Reset (rst_ni low, async) empties the table and sets the limit to 10.
// Results cannot be held off by the receiver.
module sorted_insertion_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // command item
  input  logic                                    start_i,
  output logic                                    busy_o,
  input  logic                                    op_i,
  input  logic [sit_pkg::AGE_W-1:0]               key_age_i,
  input  logic [sit_pkg::FIRST_W-1:0]             first_name_i,
  input  logic [sit_pkg::HEAD_W-1:0]              last_name_head_i,
  input  logic [sit_pkg::TAIL_W-1:0]              last_name_tail_i,
  // capacity limit register
  input  logic                                    cfg_we_i,
  input  logic [sit_pkg::CFG_W-1:0]               cfg_data_i,
  // result item
  output logic                                    valid_o,
  output logic [1:0]                              status_o,
  output logic [sit_pkg::AGE_W-1:0]               out_age_o,
  output logic [sit_pkg::FIRST_W-1:0]             out_first_name_o,
  output logic [sit_pkg::HEAD_W-1:0]              out_last_head_o,
  output logic [sit_pkg::TAIL_W-1:0]              out_last_tail_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]        fill_count_o,
  output logic                                    last_o
);
  import sit_pkg::*;

  localparam int CntW = $clog2(TABLE_DEPTH + 1);

  cmd_t   cmd;
  stat_t  stat;
  entry_t out_entry;

  // Controller: idle / dump sequencing. Inserts are decided in the idle state
  // from the datapath's full flag; a non-empty dump walks the table.
  sit_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .op_i   (op_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  // Datapath: a row of cells, each comparing its key against the new one.
  // Insert shifts the cells above the slot up by one.
  // Dump rotates the held region down so cell 0 always carries the next
  // entry; after N rotations the order is back as it was.
  sit_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .CntW       (CntW)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .key_age_i       (key_age_i),
    .first_name_i    (first_name_i),
    .last_name_head_i(last_name_head_i),
    .last_name_tail_i(last_name_tail_i),
    .valid_o         (valid_o),
    .status_o        (status_o),
    .out_entry_o     (out_entry),
    .fill_count_o    (fill_count_o),
    .last_o          (last_o)
  );

  assign out_age_o        = out_entry.age;
  assign out_first_name_o = out_entry.first;
  assign out_last_head_o  = out_entry.head;
  assign out_last_tail_o  = out_entry.tail;

endmodule
